// File: rtl/core/ios_pkg.sv
// ---------------------------------------------------------------------------
// ios_pkg
// Shared types, constants and helpers for the IMU orientation/scale block.
// ---------------------------------------------------------------------------
package ios_pkg;

  localparam int RAW_W    = 16;
  localparam int MAG_W    = 17;   // |v| up to 45179 (temperature) or 32768
  localparam int NUM_W    = 13;   // largest multiplier 981 * 8
  localparam int BIAS_W   = 12;
  localparam int SHIFT_W  = 4;
  localparam int PROD_W   = MAG_W + NUM_W;
  localparam int U_W      = 22;   // rounded dividend before the constant divide
  localparam int RECIP_W  = 20;
  localparam int DIV_W    = 8;
  localparam int Q_W      = 18;
  localparam int RES_W    = Q_W + 1;
  localparam int ACC_W    = 17;
  localparam int GYRO_W   = 16;
  localparam int TEMP_W   = 17;

  localparam int RECIP_SHIFT = 24;

  // lane numbering
  localparam int NUM_LANES = 7;
  localparam int LANE_AX   = 0;
  localparam int LANE_AY   = 1;
  localparam int LANE_AZ   = 2;
  localparam int LANE_GX   = 3;
  localparam int LANE_GY   = 4;
  localparam int LANE_GZ   = 5;
  localparam int LANE_TEMP = 6;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MOUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GYRO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ACCEL = 2'd2;

  localparam logic [2:0] MOUNT_RST = 3'd0;
  localparam logic [1:0] GYRO_RST  = 2'd1;
  localparam logic [1:0] ACCEL_RST = 2'd2;

  // accel: round(v * 981 * 2^sel / 6400) = floor(floor((x + 3200) / 256) / 25)
  localparam logic [NUM_W-1:0]   ACC_GRAV      = 13'd981;
  localparam logic [BIAS_W-1:0]  ACC_BIAS      = 12'd3200;
  localparam logic [SHIFT_W-1:0] ACC_PRE_SHIFT = 4'd8;
  localparam logic [DIV_W-1:0]   ACC_DIV       = 8'd25;
  localparam logic [RECIP_W-1:0] ACC_RECIP     = 20'd671088;   // floor(2^24 / 25)

  // gyro per range: 16/131, 32/131, 20/41, 40/41
  localparam logic [NUM_W-1:0]   GYRO_NUM   [4] = '{13'd16, 13'd32, 13'd20, 13'd40};
  localparam logic [BIAS_W-1:0]  GYRO_BIAS  [4] = '{12'd65, 12'd65, 12'd20, 12'd20};
  localparam logic [DIV_W-1:0]   GYRO_DIV   [4] = '{8'd131, 8'd131, 8'd41, 8'd41};
  localparam logic [RECIP_W-1:0] GYRO_RECIP [4] =
    '{20'd128070, 20'd128070, 20'd409200, 20'd409200};

  // temperature: round((raw + 12412) * 64 / 85)
  localparam logic signed [MAG_W-1:0] TEMP_OFFSET = 17'sd12412;
  localparam logic [NUM_W-1:0]   TEMP_NUM   = 13'd64;
  localparam logic [BIAS_W-1:0]  TEMP_BIAS  = 12'd42;
  localparam logic [DIV_W-1:0]   TEMP_DIV   = 8'd85;
  localparam logic [RECIP_W-1:0] TEMP_RECIP = 20'd197379;      // floor(2^24 / 85)

  localparam logic [SHIFT_W-1:0] NO_SHIFT = 4'd0;

  typedef struct packed {
    logic x_from_y;
    logic neg_x;
    logic neg_y;
    logic neg_z;
  } remap_t;

  localparam remap_t REMAP_TAB [8] = '{
    '{1'b1, 1'b0, 1'b0, 1'b1}, '{1'b0, 1'b0, 1'b1, 1'b1},
    '{1'b1, 1'b1, 1'b1, 1'b1}, '{1'b0, 1'b1, 1'b0, 1'b1},
    '{1'b1, 1'b0, 1'b1, 1'b0}, '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b1, 1'b1, 1'b0, 1'b0}, '{1'b0, 1'b0, 1'b1, 1'b0}
  };

  typedef struct packed {
    logic             sign;
    logic [MAG_W-1:0] mag;
  } lane_in_t;

  typedef struct packed {
    logic [NUM_W-1:0]   num;
    logic [BIAS_W-1:0]  bias;
    logic [SHIFT_W-1:0] pre_shift;
    logic [DIV_W-1:0]   div;
    logic [RECIP_W-1:0] recip;
  } lane_coef_t;

  function automatic lane_in_t to_sign_mag(logic signed [MAG_W-1:0] v);
    lane_in_t r;
    r.sign = v[MAG_W-1];
    r.mag  = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
    return r;
  endfunction

endpackage

// File: rtl/core/ios_front.sv
// ---------------------------------------------------------------------------
// ios_front
// Axis remap per mounting orientation, temperature offset, and split of every
// word into sign and magnitude for the lanes. One register stage.
// ---------------------------------------------------------------------------
module ios_front (
  input  logic                         clk,
  input  logic                         en,
  input  logic [2:0]                   mount,
  input  logic signed [ios_pkg::RAW_W-1:0] accel_x_raw,
  input  logic signed [ios_pkg::RAW_W-1:0] accel_y_raw,
  input  logic signed [ios_pkg::RAW_W-1:0] accel_z_raw,
  input  logic signed [ios_pkg::RAW_W-1:0] temp_raw,
  input  logic signed [ios_pkg::RAW_W-1:0] gyro_x_raw,
  input  logic signed [ios_pkg::RAW_W-1:0] gyro_y_raw,
  input  logic signed [ios_pkg::RAW_W-1:0] gyro_z_raw,
  output ios_pkg::lane_in_t            lane_in [ios_pkg::NUM_LANES]
);
  import ios_pkg::*;

  remap_t   rm;
  lane_in_t lane_nxt [NUM_LANES];
  lane_in_t lane_r   [NUM_LANES];
  logic signed [MAG_W-1:0] sx [2];
  logic signed [MAG_W-1:0] sy [2];
  logic signed [MAG_W-1:0] sz [2];
  logic signed [MAG_W-1:0] bx [2];
  logic signed [MAG_W-1:0] by [2];
  logic signed [MAG_W-1:0] bz [2];
  logic signed [MAG_W-1:0] temp_w;

  assign rm = REMAP_TAB[mount];

  always_comb begin
    // group 0 accel, group 1 gyro; 17 bits so that -(-32768) does not wrap
    sx[0] = MAG_W'(accel_x_raw);
    sy[0] = MAG_W'(accel_y_raw);
    sz[0] = MAG_W'(accel_z_raw);
    sx[1] = MAG_W'(gyro_x_raw);
    sy[1] = MAG_W'(gyro_y_raw);
    sz[1] = MAG_W'(gyro_z_raw);
    for (int g = 0; g < 2; g++) begin
      bx[g] = rm.x_from_y ? sy[g] : sx[g];
      by[g] = rm.x_from_y ? sx[g] : sy[g];
      bz[g] = sz[g];
      if (rm.neg_x) bx[g] = -bx[g];
      if (rm.neg_y) by[g] = -by[g];
      if (rm.neg_z) bz[g] = -bz[g];
    end
    temp_w = MAG_W'(temp_raw) + TEMP_OFFSET;

    lane_nxt[LANE_AX]   = to_sign_mag(bx[0]);
    lane_nxt[LANE_AY]   = to_sign_mag(by[0]);
    lane_nxt[LANE_AZ]   = to_sign_mag(bz[0]);
    lane_nxt[LANE_GX]   = to_sign_mag(bx[1]);
    lane_nxt[LANE_GY]   = to_sign_mag(by[1]);
    lane_nxt[LANE_GZ]   = to_sign_mag(bz[1]);
    lane_nxt[LANE_TEMP] = to_sign_mag(temp_w);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_r <= lane_nxt;
    end
  end

  assign lane_in = lane_r;

endmodule

// File: rtl/core/ios_lane.sv
// ---------------------------------------------------------------------------
// ios_lane
// One scaling lane: round(mag * num / den) by multiply, bias, shift, then a
// reciprocal divide with one correction step. Sign is reapplied at the end.
// ---------------------------------------------------------------------------
module ios_lane (
  input  logic                                clk,
  input  logic                                en,
  input  ios_pkg::lane_in_t                   lane_in,
  input  ios_pkg::lane_coef_t                 coef,
  output logic signed [ios_pkg::RES_W-1:0]    result
);
  import ios_pkg::*;

  localparam int QD_W = Q_W + DIV_W;

  logic [PROD_W-1:0]          prod;
  logic [PROD_W-1:0]          biased;
  logic [U_W-1:0]             u_nxt;
  logic [U_W-1:0]             u_a_r;
  logic                       sign_a_r;
  logic [U_W+RECIP_W-1:0]     recip_prod;
  logic [Q_W-1:0]             q0_nxt;
  logic [Q_W-1:0]             q0_b_r;
  logic [U_W-1:0]             u_b_r;
  logic                       sign_b_r;
  logic [QD_W-1:0]            qd;
  logic [QD_W-1:0]            rem;
  logic [Q_W-1:0]             q;
  logic signed [RES_W-1:0]    q_s;

  // stage A: scale and add the rounding bias
  always_comb begin
    prod   = PROD_W'(lane_in.mag) * PROD_W'(coef.num);
    biased = prod + PROD_W'(coef.bias);
    u_nxt  = U_W'(biased >> coef.pre_shift);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_a_r    <= u_nxt;
      sign_a_r <= lane_in.sign;
    end
  end

  // stage B: quotient estimate, low by at most one
  always_comb begin
    recip_prod = (U_W+RECIP_W)'(u_a_r) * (U_W+RECIP_W)'(coef.recip);
    q0_nxt     = Q_W'(recip_prod >> RECIP_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q0_b_r   <= q0_nxt;
      u_b_r    <= u_a_r;
      sign_b_r <= sign_a_r;
    end
  end

  // correction and sign; registered by the merge stage
  always_comb begin
    qd     = QD_W'(q0_b_r) * QD_W'(coef.div);
    rem    = QD_W'(u_b_r) - qd;
    q      = q0_b_r + Q_W'(rem >= QD_W'(coef.div));
    q_s    = signed'({1'b0, q});
    result = sign_b_r ? -q_s : q_s;
  end

endmodule

// File: rtl/core/imu_orient_scale.sv
// ---------------------------------------------------------------------------
// imu_orient_scale
// Remaps a seven-word inertial burst to the body frame and scales it to
// physical units, seven lanes side by side with a common output register.
// ---------------------------------------------------------------------------
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | 7 raw sensor words, 16 bit signed
//   out_    | output    | out_valid/out_stall| accel x/y/z, gyro x/y/z, temperature
//   cfg_    | input     | cfg_wr_en          | cfg_index, cfg_wdata (3 bits)
//
// One request per cycle while the pipe is not held; a request passes the front
// register, the two lane stages of the reciprocal divide and the output register.
// The whole pipe advances together; it holds while out_stall keeps a result
// waiting, and in_stall is high exactly then. Reset is synchronous and
// clears the valid bits and the configuration registers.
// ---------------------------------------------------------------------------
module imu_orient_scale (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [ios_pkg::RAW_W-1:0]       in_accel_x_raw,
  input  logic signed [ios_pkg::RAW_W-1:0]       in_accel_y_raw,
  input  logic signed [ios_pkg::RAW_W-1:0]       in_accel_z_raw,
  input  logic signed [ios_pkg::RAW_W-1:0]       in_temp_raw,
  input  logic signed [ios_pkg::RAW_W-1:0]       in_gyro_x_raw,
  input  logic signed [ios_pkg::RAW_W-1:0]       in_gyro_y_raw,
  input  logic signed [ios_pkg::RAW_W-1:0]       in_gyro_z_raw,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [ios_pkg::ACC_W-1:0]       out_accel_x,
  output logic signed [ios_pkg::ACC_W-1:0]       out_accel_y,
  output logic signed [ios_pkg::ACC_W-1:0]       out_accel_z,
  output logic signed [ios_pkg::GYRO_W-1:0]      out_gyro_x,
  output logic signed [ios_pkg::GYRO_W-1:0]      out_gyro_y,
  output logic signed [ios_pkg::GYRO_W-1:0]      out_gyro_z,
  output logic signed [ios_pkg::TEMP_W-1:0]      out_temperature,
  input  logic                                   cfg_wr_en,
  input  logic [ios_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ios_pkg::CFG_DATA_W-1:0]         cfg_wdata
);
  import ios_pkg::*;

  logic [2:0] mount_r;
  logic [1:0] gyro_sel_r;
  logic [1:0] accel_sel_r;

  logic       en;
  logic       v1_r;
  logic       v2_r;
  logic       v3_r;
  logic       out_valid_r;

  lane_in_t                lane_in  [NUM_LANES];
  lane_coef_t              lane_coef [NUM_LANES];
  logic signed [RES_W-1:0] lane_res [NUM_LANES];
  lane_coef_t              acc_coef;
  lane_coef_t              gyro_coef;
  lane_coef_t              temp_coef;

  logic signed [ACC_W-1:0]  out_accel_x_r;
  logic signed [ACC_W-1:0]  out_accel_y_r;
  logic signed [ACC_W-1:0]  out_accel_z_r;
  logic signed [GYRO_W-1:0] out_gyro_x_r;
  logic signed [GYRO_W-1:0] out_gyro_y_r;
  logic signed [GYRO_W-1:0] out_gyro_z_r;
  logic signed [TEMP_W-1:0] out_temperature_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mount_r     <= MOUNT_RST;
      gyro_sel_r  <= GYRO_RST;
      accel_sel_r <= ACCEL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_IDX_MOUNT: mount_r     <= cfg_wdata[2:0];
        CFG_IDX_GYRO:  gyro_sel_r  <= cfg_wdata[1:0];
        CFG_IDX_ACCEL: accel_sel_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // pipe advances unless a finished result is held
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  // per-lane constants, picked by the range registers
  always_comb begin
    acc_coef.num       = ACC_GRAV << accel_sel_r;
    acc_coef.bias      = ACC_BIAS;
    acc_coef.pre_shift = ACC_PRE_SHIFT;
    acc_coef.div       = ACC_DIV;
    acc_coef.recip     = ACC_RECIP;

    gyro_coef.num       = GYRO_NUM[gyro_sel_r];
    gyro_coef.bias      = GYRO_BIAS[gyro_sel_r];
    gyro_coef.pre_shift = NO_SHIFT;
    gyro_coef.div       = GYRO_DIV[gyro_sel_r];
    gyro_coef.recip     = GYRO_RECIP[gyro_sel_r];

    temp_coef.num       = TEMP_NUM;
    temp_coef.bias      = TEMP_BIAS;
    temp_coef.pre_shift = NO_SHIFT;
    temp_coef.div       = TEMP_DIV;
    temp_coef.recip     = TEMP_RECIP;

    lane_coef[LANE_AX]   = acc_coef;
    lane_coef[LANE_AY]   = acc_coef;
    lane_coef[LANE_AZ]   = acc_coef;
    lane_coef[LANE_GX]   = gyro_coef;
    lane_coef[LANE_GY]   = gyro_coef;
    lane_coef[LANE_GZ]   = gyro_coef;
    lane_coef[LANE_TEMP] = temp_coef;
  end

  ios_front u_front (
    .clk         (clk),
    .en          (en),
    .mount       (mount_r),
    .accel_x_raw (in_accel_x_raw),
    .accel_y_raw (in_accel_y_raw),
    .accel_z_raw (in_accel_z_raw),
    .temp_raw    (in_temp_raw),
    .gyro_x_raw  (in_gyro_x_raw),
    .gyro_y_raw  (in_gyro_y_raw),
    .gyro_z_raw  (in_gyro_z_raw),
    .lane_in     (lane_in)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    ios_lane u_lane (
      .clk     (clk),
      .en      (en),
      .lane_in (lane_in[i]),
      .coef    (lane_coef[i]),
      .result  (lane_res[i])
    );
  end

  // merge: collect the lane results into the output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_accel_x_r     <= ACC_W'(lane_res[LANE_AX]);
      out_accel_y_r     <= ACC_W'(lane_res[LANE_AY]);
      out_accel_z_r     <= ACC_W'(lane_res[LANE_AZ]);
      out_gyro_x_r      <= GYRO_W'(lane_res[LANE_GX]);
      out_gyro_y_r      <= GYRO_W'(lane_res[LANE_GY]);
      out_gyro_z_r      <= GYRO_W'(lane_res[LANE_GZ]);
      out_temperature_r <= TEMP_W'(lane_res[LANE_TEMP]);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_accel_x     = out_accel_x_r;
  assign out_accel_y     = out_accel_y_r;
  assign out_accel_z     = out_accel_z_r;
  assign out_gyro_x      = out_gyro_x_r;
  assign out_gyro_y      = out_gyro_y_r;
  assign out_gyro_z      = out_gyro_z_r;
  assign out_temperature = out_temperature_r;

endmodule

// File: tb/imu_orient_scale_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// imu_orient_scale_tb
// Drives seven-word sensor bursts through imu_orient_scale under a sweep of
// mounting orientations and full-scale ranges. Each accepted request is
// predicted in the bench and checked field by field against the results.
// ---------------------------------------------------------------------------
module imu_orient_scale_tb;

  localparam int RAW_W  = ios_pkg::RAW_W;
  localparam int ACC_W  = ios_pkg::ACC_W;
  localparam int GYRO_W = ios_pkg::GYRO_W;
  localparam int TEMP_W = ios_pkg::TEMP_W;
  localparam int IDX_W  = ios_pkg::CFG_IDX_W;
  localparam int DAT_W  = ios_pkg::CFG_DATA_W;

  // index past the register list, writes to it must be dropped
  localparam logic [IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  localparam longint GRAV_CENTI    = 981;
  localparam longint ACC_DIVISOR   = 6400;
  localparam longint TEMP_ZERO_OFS = 12412;
  localparam longint TEMP_MUL      = 64;
  localparam longint TEMP_DIVISOR  = 85;

  localparam int NUM_SETTINGS   = 16;
  localparam int FRAMES_PER_SET = 28;
  localparam int HOLD_AT        = 380;
  localparam int HOLD_LEN       = 60;
  localparam int DRAIN_CYCLES   = 8;

  typedef enum logic [1:0] {
    PACE_SEND_LIGHT,  // sender idles rarely, receiver stalls a lot
    PACE_SEND_HEAVY,  // the other way round
    PACE_FREE
  } pace_t;

  typedef struct {
    logic signed [RAW_W-1:0] ax, ay, az, temp, gx, gy, gz;
  } raw_frame_t;

  typedef struct {
    logic signed [ACC_W-1:0]  ax, ay, az;
    logic signed [GYRO_W-1:0] gx, gy, gz;
    logic signed [TEMP_W-1:0] temp;
  } body_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [RAW_W-1:0] in_accel_x_raw = '0, in_accel_y_raw = '0, in_accel_z_raw = '0;
  logic signed [RAW_W-1:0] in_temp_raw = '0;
  logic signed [RAW_W-1:0] in_gyro_x_raw = '0, in_gyro_y_raw = '0, in_gyro_z_raw = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ACC_W-1:0]  out_accel_x, out_accel_y, out_accel_z;
  logic signed [GYRO_W-1:0] out_gyro_x, out_gyro_y, out_gyro_z;
  logic signed [TEMP_W-1:0] out_temperature;
  logic cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DAT_W-1:0] cfg_wdata = '0;

  // bench copy of the register file, reset values
  logic [2:0] mount_sel = 3'd0;
  logic [1:0] gyro_sel  = 2'd1;
  logic [1:0] accel_sel = 2'd2;

  raw_frame_t  pending_frames [$];
  body_frame_t body_expected [$];
  raw_frame_t  cur_frame;
  pace_t       pace = PACE_SEND_LIGHT;

  int frames_queued   = 0;
  int frames_accepted = 0;
  int results_seen    = 0;
  int mismatches      = 0;
  int hold_left       = 0;
  bit hold_done       = 1'b0;

  imu_orient_scale uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_accel_x_raw  (in_accel_x_raw),
    .in_accel_y_raw  (in_accel_y_raw),
    .in_accel_z_raw  (in_accel_z_raw),
    .in_temp_raw     (in_temp_raw),
    .in_gyro_x_raw   (in_gyro_x_raw),
    .in_gyro_y_raw   (in_gyro_y_raw),
    .in_gyro_z_raw   (in_gyro_z_raw),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_accel_x     (out_accel_x),
    .out_accel_y     (out_accel_y),
    .out_accel_z     (out_accel_z),
    .out_gyro_x      (out_gyro_x),
    .out_gyro_y      (out_gyro_y),
    .out_gyro_z      (out_gyro_z),
    .out_temperature (out_temperature),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- prediction ----------------

  // nearest, ties away from zero
  function automatic longint round_div(longint n, longint d);
    if (n >= 0) begin
      return (n + d / 2) / d;
    end
    return -((-n + d / 2) / d);
  endfunction

  // sensor frame to body frame; -32768 negates to +32768 in 64 bits
  function automatic void orient_axes(input longint sx, input longint sy, input longint sz,
                                      output longint bx, output longint by,
                                      output longint bz);
    logic swap_xy, neg_x, neg_y;
    longint px, py;
    unique case (mount_sel)
      3'd0: {swap_xy, neg_x, neg_y} = 3'b100;
      3'd1: {swap_xy, neg_x, neg_y} = 3'b001;
      3'd2: {swap_xy, neg_x, neg_y} = 3'b111;
      3'd3: {swap_xy, neg_x, neg_y} = 3'b010;
      3'd4: {swap_xy, neg_x, neg_y} = 3'b101;
      3'd5: {swap_xy, neg_x, neg_y} = 3'b010;
      3'd6: {swap_xy, neg_x, neg_y} = 3'b110;
      default: {swap_xy, neg_x, neg_y} = 3'b001;
    endcase
    px = swap_xy ? sy : sx;
    py = swap_xy ? sx : sy;
    bx = neg_x ? -px : px;
    by = neg_y ? -py : py;
    // top mounts flip Z, bottom mounts keep it
    bz = mount_sel[2] ? sz : -sz;
  endfunction

  function automatic body_frame_t scale_frame(raw_frame_t f);
    body_frame_t r;
    longint ax, ay, az, gx, gy, gz, amul, gnum, gden;
    orient_axes(longint'(f.ax), longint'(f.ay), longint'(f.az), ax, ay, az);
    orient_axes(longint'(f.gx), longint'(f.gy), longint'(f.gz), gx, gy, gz);
    amul = GRAV_CENTI << accel_sel;
    unique case (gyro_sel)
      2'd0: begin gnum = 16; gden = 131; end
      2'd1: begin gnum = 32; gden = 131; end
      2'd2: begin gnum = 20; gden = 41; end
      default: begin gnum = 40; gden = 41; end
    endcase
    r.ax   = ACC_W'(round_div(ax * amul, ACC_DIVISOR));
    r.ay   = ACC_W'(round_div(ay * amul, ACC_DIVISOR));
    r.az   = ACC_W'(round_div(az * amul, ACC_DIVISOR));
    r.gx   = GYRO_W'(round_div(gx * gnum, gden));
    r.gy   = GYRO_W'(round_div(gy * gnum, gden));
    r.gz   = GYRO_W'(round_div(gz * gnum, gden));
    r.temp = TEMP_W'(round_div((longint'(f.temp) + TEMP_ZERO_OFS) * TEMP_MUL, TEMP_DIVISOR));
    return r;
  endfunction

  function automatic int send_idle_pct(pace_t p);
    unique case (p)
      PACE_SEND_LIGHT: return 38;
      PACE_SEND_HEAVY: return 85;
      default:         return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(pace_t p);
    unique case (p)
      PACE_SEND_LIGHT: return 85;
      PACE_SEND_HEAVY: return 38;
      default:         return 0;
    endcase
  endfunction

  // ---------------- sender ----------------

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        body_expected.push_back(scale_frame(cur_frame));
        frames_accepted <= frames_accepted + 1;
      end
      // a stalled request keeps valid and payload
      if (!in_valid || !in_stall) begin
        if (pending_frames.size() > 0 && $urandom_range(0, 99) >= send_idle_pct(pace)) begin
          cur_frame = pending_frames.pop_front();
          in_valid       <= 1'b1;
          in_accel_x_raw <= cur_frame.ax;
          in_accel_y_raw <= cur_frame.ay;
          in_accel_z_raw <= cur_frame.az;
          in_temp_raw    <= cur_frame.temp;
          in_gyro_x_raw  <= cur_frame.gx;
          in_gyro_y_raw  <= cur_frame.gy;
          in_gyro_z_raw  <= cur_frame.gz;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver ----------------

  // one long hold-off while the sender keeps offering, fills the pipe
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && frames_accepted >= HOLD_AT) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct(pace));
      end
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] result %0d %s: expected %0d, got %0d",
                 $realtime, results_seen, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    body_frame_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (body_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result with no request outstanding", $realtime);
        end
      end else begin
        want = body_expected.pop_front();
        check_field("accel_x", longint'(want.ax), longint'(out_accel_x));
        check_field("accel_y", longint'(want.ay), longint'(out_accel_y));
        check_field("accel_z", longint'(want.az), longint'(out_accel_z));
        check_field("gyro_x", longint'(want.gx), longint'(out_gyro_x));
        check_field("gyro_y", longint'(want.gy), longint'(out_gyro_y));
        check_field("gyro_z", longint'(want.gz), longint'(out_gyro_z));
        check_field("temperature", longint'(want.temp), longint'(out_temperature));
      end
      results_seen++;
    end
  end

  // ---------------- stimulus ----------------

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DAT_W-1:0] data);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    unique case (idx)
      ios_pkg::CFG_IDX_MOUNT: mount_sel = data[2:0];
      ios_pkg::CFG_IDX_GYRO:  gyro_sel  = data[1:0];
      ios_pkg::CFG_IDX_ACCEL: accel_sel = data[1:0];
      default: ;
    endcase
  endtask

  task automatic add_frame(input longint ax, input longint ay, input longint az,
                           input longint temp, input longint gx, input longint gy,
                           input longint gz);
    raw_frame_t f;
    f.ax = RAW_W'(ax); f.ay = RAW_W'(ay); f.az = RAW_W'(az); f.temp = RAW_W'(temp);
    f.gx = RAW_W'(gx); f.gy = RAW_W'(gy); f.gz = RAW_W'(gz);
    pending_frames.push_back(f);
    frames_queued++;
  endtask

  // full-scale words, rounding ties for the accel ranges, temperature zero
  function automatic longint rand_word();
    if ($urandom_range(0, 4) != 0) begin
      return longint'($signed(RAW_W'($urandom)));
    end
    unique case ($urandom_range(0, 14))
      0:  return -32768;
      1:  return 32767;
      2:  return -32767;
      3:  return 0;
      4:  return 1;
      5:  return -1;
      6:  return 3200;
      7:  return -3200;
      8:  return 1600;
      9:  return -1600;
      10: return 800;
      11: return -800;
      12: return 400;
      13: return -400;
      default: return -TEMP_ZERO_OFS;
    endcase
  endfunction

  task automatic drain();
    while (frames_accepted != frames_queued || body_expected.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values; full scale, signs, axis markers, ties
    add_frame(0, 0, 0, 0, 0, 0, 0);
    add_frame(32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_frame(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_frame(-1, -1, -1, -1, -1, -1, -1);
    add_frame(1, 1, 1, 1, 1, 1, 1);
    add_frame(1000, 2000, 3000, -TEMP_ZERO_OFS, 100, 200, 300);
    add_frame(-32768, 32767, -32768, 32767, -32768, 32767, -32768);
    add_frame(32767, -32768, 32767, -32768, 32767, -32768, 32767);
    add_frame(800, -800, 800, -12411, 65, -65, 66);
    add_frame(-800, 800, -800, -12413, -66, 66, -65);
    add_frame(16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555);
    add_frame(-21846, -21846, -21846, -21846, -21846, -21846, -21846);
    drain();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      pace = (s < 6) ? PACE_SEND_LIGHT : (s < 11) ? PACE_SEND_HEAVY : PACE_FREE;
      write_reg(ios_pkg::CFG_IDX_MOUNT, DAT_W'(s % 8));
      // upper data bit is outside the range registers and must be ignored
      write_reg(ios_pkg::CFG_IDX_GYRO, {1'($urandom), 2'(s % 4)});
      write_reg(ios_pkg::CFG_IDX_ACCEL, {1'($urandom), 2'(s / 4)});
      if (s % 3 == 0) begin
        write_reg(CFG_IDX_SPARE, DAT_W'($urandom));
      end
      for (int i = 0; i < FRAMES_PER_SET; i++) begin
        add_frame(rand_word(), rand_word(), rand_word(), rand_word(),
                  rand_word(), rand_word(), rand_word());
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results over %0d register settings: all mountings, ranges and",
             results_seen, NUM_SETTINGS + 1);
    $display("full-scale words, with random stalls on both sides and one long hold-off");
    if (mismatches == 0 && body_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ios_pkg.sv
rtl/core/ios_front.sv
rtl/core/ios_lane.sv
rtl/core/imu_orient_scale.sv
tb/imu_orient_scale_tb.sv
